>>> rtl/wtsc_pkg.sv
// Shared types, codes and helpers for the wave-table sound channel.
package wtsc_pkg;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_TRIGGER = 2'd3;

    localparam logic [1:0] CFG_FREQUENCY    = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_LEVEL = 2'd1;
    localparam logic [1:0] CFG_DAC_ENABLE   = 2'd2;

    localparam logic [7:0] ADDR_NR30      = 8'h1A;
    localparam logic [7:0] ADDR_NR32      = 8'h1C;
    localparam logic [3:0] ADDR_WAVE_PAGE = 4'h3;

    localparam int          WAVE_BYTES  = 16;
    localparam int          WAVE_AW     = $clog2(WAVE_BYTES);
    localparam logic [11:0] PERIOD_BASE = 12'd2048;
    localparam int          CFG_DW      = 11;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] address;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [3:0] sample;
        logic [7:0] read_data;
        logic       channel_on;
        logic [4:0] position;
    } t_out_item;

    // Volume code to right shift: mute, full, half, quarter.
    function automatic logic [2:0] level_shift(input logic [1:0] level);
        logic [2:0] s;
        case (level)
            2'd0:    s = 3'd4;
            2'd1:    s = 3'd0;
            2'd2:    s = 3'd1;
            2'd3:    s = 3'd2;
            default: s = 3'd4;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/wtsc_wave_ram.sv
// Wave RAM: 16 bytes, one write port, two registered read ports, write forwarding.
module wtsc_wave_ram
    import wtsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_re,
    input  logic               i_we,
    input  logic [WAVE_AW-1:0] i_waddr,
    input  logic [7:0]         i_wdata,
    input  logic [WAVE_AW-1:0] i_raddr_a,
    input  logic [WAVE_AW-1:0] i_raddr_b,
    output logic [7:0]         o_rdata_a,
    output logic [7:0]         o_rdata_b
);

    logic [7:0]            mem [WAVE_BYTES];
    logic [WAVE_BYTES-1:0] r_valid;
    logic [7:0]            r_mem_a, r_mem_b, r_wdata;
    logic                  r_vld_a, r_vld_b, r_fwd_a, r_fwd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_mem_a <= mem[i_raddr_a];
            r_mem_b <= mem[i_raddr_b];
            r_wdata <= i_wdata;
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_vld_a <= r_valid[i_raddr_a];
                r_vld_b <= r_valid[i_raddr_b];
                r_fwd_a <= i_we && (i_waddr == i_raddr_a);
                r_fwd_b <= i_we && (i_waddr == i_raddr_b);
            end
        end
    end

    assign o_rdata_a = r_fwd_a ? r_wdata : (r_vld_a ? r_mem_a : 8'h00);
    assign o_rdata_b = r_fwd_b ? r_wdata : (r_vld_b ? r_mem_b : 8'h00);

endmodule

>>> rtl/wave_table_sound_channel_core.sv
// Wave-table sound channel: timer, position, trigger and wave RAM access.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------
//  in       | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out      | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg      | i_cfg_we                  | i_cfg_index, i_cfg_wdata
//
// One request per cycle unless the output stalls; an accepted request passes the read stage, then the output register.
// Timer, position and channel flag update at acceptance; wave RAM is read then
// and its registered data forms the result in the next stage.
// Synchronous active-low reset clears control state and marks all wave RAM
// entries empty (reading zero); no clearing pass is needed.
// An output stall holds the read stage; input is taken while either slot frees.
module wave_table_sound_channel_core
    import wtsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    logic [10:0] r_frequency;
    logic [1:0]  r_output_level;
    logic        r_dac_enable;

    logic [12:0] r_timer, n_timer;
    logic [4:0]  r_index, n_index;
    logic        r_on, n_on;

    logic        r_s1_valid;
    logic        r_s1_wave_rd;
    logic [7:0]  r_s1_reg_rd;
    logic        r_s1_on;
    logic [4:0]  r_s1_pos;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        in_accept, s1_adv;
    logic        in_wave;
    logic        ram_we;
    logic [7:0]  rd_a, rd_b;
    logic [7:0]  reg_rd;
    logic [3:0]  nib;
    t_out_item   s1_item;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    assign in_wave = (i_in_data.address[7:4] == ADDR_WAVE_PAGE);
    assign ram_we  = in_accept && (i_in_data.opcode == OP_WRITE) && in_wave;

    always_comb begin
        n_timer = r_timer;
        n_index = r_index;
        n_on    = r_on;
        case (i_in_data.opcode)
            OP_TICK: begin
                if (r_timer <= 13'd1) begin
                    n_timer = {PERIOD_BASE - {1'b0, r_frequency}, 1'b0};
                    n_index = r_index + 5'd1;
                end else begin
                    n_timer = r_timer - 13'd1;
                end
            end
            OP_TRIGGER: begin
                n_index = 5'd1;
                n_on    = r_on | r_dac_enable;
            end
            default: ;
        endcase
    end

    always_comb begin
        reg_rd = 8'h00;
        if (i_in_data.opcode == OP_READ) begin
            if (i_in_data.address == ADDR_NR30) begin
                reg_rd = {r_dac_enable, 7'd0};
            end else if (i_in_data.address == ADDR_NR32) begin
                reg_rd = {1'b0, r_output_level, 5'd0};
            end
        end
    end

    wtsc_wave_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (in_accept),
        .i_we      (ram_we),
        .i_waddr   (i_in_data.address[WAVE_AW-1:0]),
        .i_wdata   (i_in_data.write_data),
        .i_raddr_a (n_index[4:1]),
        .i_raddr_b (i_in_data.address[WAVE_AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // High nibble first within each byte.
    assign nib = r_s1_pos[0] ? rd_a[3:0] : rd_a[7:4];

    always_comb begin
        s1_item.sample     = nib >> level_shift(r_output_level);
        s1_item.read_data  = r_s1_wave_rd ? rd_b : r_s1_reg_rd;
        s1_item.channel_on = r_s1_on;
        s1_item.position   = r_s1_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frequency    <= '0;
            r_output_level <= '0;
            r_dac_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FREQUENCY:    r_frequency    <= i_cfg_wdata[10:0];
                CFG_OUTPUT_LEVEL: r_output_level <= i_cfg_wdata[1:0];
                CFG_DAC_ENABLE:   r_dac_enable   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= '0;
            r_index     <= '0;
            r_on        <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_timer <= n_timer;
                r_index <= n_index;
                r_on    <= n_on;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_wave_rd <= (i_in_data.opcode == OP_READ) && in_wave;
            r_s1_reg_rd  <= reg_rd;
            r_s1_on      <= n_on;
            r_s1_pos     <= n_index;
        end
        if (s1_adv) begin
            r_out <= s1_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/wtsc_checker.sv
// Port-level checks for the wave-table sound channel, bound to the top level.
module wtsc_checker
    import wtsc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input t_in_item          i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_data,
    input logic              i_cfg_we,
    input logic [1:0]        i_cfg_index,
    input logic [CFG_DW-1:0] i_cfg_wdata
);

    logic [1:0] r_level;
    logic       r_seen_on;

    // Shadow the volume code and whether the channel was ever reported on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_seen_on <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_OUTPUT_LEVEL)) begin
                r_level <= i_cfg_wdata[1:0];
            end
            if (o_out_valid && i_out_ready && o_out_data.channel_on) begin
                r_seen_on <= 1'b1;
            end
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input request dropped or changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result request dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_level != 2'd0 || o_out_data.sample == 4'd0) &&
                        (r_level != 2'd2 || o_out_data.sample[3] == 1'b0) &&
                        (r_level != 2'd3 || o_out_data.sample[3:2] == 2'd0))
        else $error("sample exceeds range of output level");

    a_on_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_on |-> o_out_data.channel_on)
        else $error("channel flag cleared without reset");

endmodule

bind wave_table_sound_channel_core wtsc_checker u_wtsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_wdata (i_cfg_wdata)
);
